// ===== sv/biq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad filter package
// Widths, register indexes and the coefficient bundle shared by the design.
// ----------------------------------------------------------------------------
package biq_pkg;

    localparam int SAMPLE_BITS    = 12;
    localparam int OUT_FRAC_BITS  = 8;
    localparam int IN_FRAC_BITS   = 2;
    localparam int COEF_W         = 16;
    localparam int COEF_FRAC_BITS = 14;
    localparam int Y_W            = 32;
    localparam int CODE_W         = 10;
    localparam int NUM_COEFS      = 5;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = COEF_W;

    // Feed-forward product and sum widths (coefficient times zero-extended sample).
    localparam int FF_P_W = COEF_W + SAMPLE_BITS + 1;
    localparam int FF_W   = FF_P_W + 2;
    // Feedback product and sum widths.
    localparam int FB_P_W = COEF_W + Y_W;
    localparam int FB_W   = FB_P_W + 1;
    // Aligned accumulator, one guard bit over the wider addend.
    localparam int ACC_W  = (((FF_W + OUT_FRAC_BITS) > (FB_W + IN_FRAC_BITS)) ?
                             (FF_W + OUT_FRAC_BITS) : (FB_W + IN_FRAC_BITS)) + 1;
    localparam int ACC_SHIFT = IN_FRAC_BITS + COEF_FRAC_BITS;
    localparam int YW_W      = ACC_W - ACC_SHIFT;
    localparam int IP_W      = Y_W - OUT_FRAC_BITS;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_B0 = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_B1 = t_cfg_idx'(1);
    localparam t_cfg_idx CFG_B2 = t_cfg_idx'(2);
    localparam t_cfg_idx CFG_A1 = t_cfg_idx'(3);
    localparam t_cfg_idx CFG_A2 = t_cfg_idx'(4);

    localparam logic signed [COEF_W-1:0] B0_RESET = 16'sd16384;   //  1.0
    localparam logic signed [COEF_W-1:0] B1_RESET = -16'sd24248;  // -1.48
    localparam logic signed [COEF_W-1:0] B2_RESET = 16'sd16205;   //  0.9891
    localparam logic signed [COEF_W-1:0] A1_RESET = 16'sd22495;   //  1.373
    localparam logic signed [COEF_W-1:0] A2_RESET = -16'sd14449;  // -0.8819

    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
    } t_coefs;

endpackage

// ===== sv/biq_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad stream interfaces
// Sample input channel and DAC code output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface biq_in_if;
    logic                            valid;
    logic                            ready;
    logic [biq_pkg::SAMPLE_BITS-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

interface biq_out_if;
    logic                       valid;
    logic                       ready;
    logic [biq_pkg::CODE_W-1:0] dac_code;
    logic                       clipped;

    modport source (output valid, output dac_code, output clipped, input ready);
    modport sink   (input valid, input dac_code, input clipped, output ready);
endinterface

// ===== sv/biquad_iir_sample_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad IIR sample filter
// Direct-form-I second-order filter from ADC samples to clamped DAC codes.
// ----------------------------------------------------------------------------
// One word in, one word out, one word per clock sustained while the output
// is taken. A sample is captured in an input register; when the output
// register is free or drains, the five products, the sum, the floor shift,
// the 32-bit saturation and the 0..1023 clamp run in one combinational pass,
// the history (two samples, two outputs) steps and the code lands in the
// output register, which raises the output valid. The feedback from the
// output history through the 16x32 coefficient multipliers and the
// accumulator sets the clock period. Both registers move together, so a new
// sample is taken in the same cycle a waiting code is taken. Coefficients
// are Q2.14 and are written through the plain write port (index 0..4: b0,
// b1, b2, a1, a2); the user must write them only while idle, the block does
// not enforce this. Writes to other indexes are dropped. Reset restores the
// default filter coefficients and clears the history.
// ----------------------------------------------------------------------------
module biquad_iir_sample_filter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    biq_in_if.sink                         i_in,
    biq_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  biq_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [biq_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    biq_pkg::t_coefs                 coefs;
    logic                            r_in_vld;
    logic [biq_pkg::SAMPLE_BITS-1:0] r_sample;
    logic                            r_out_vld;
    logic [biq_pkg::CODE_W-1:0]      r_code;
    logic                            r_clip;
    logic [biq_pkg::CODE_W-1:0]      n_code;
    logic                            n_clip;
    logic                            advance;
    logic                            in_take;

    // Advance the held sample when the output register is free or drains now.
    assign advance  = r_in_vld && (!r_out_vld || o_out.ready);
    assign in_take  = i_in.valid && i_in.ready;
    assign i_in.ready = !r_in_vld || advance;

    biq_coef_regs u_coef_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_coefs    (coefs)
    );

    biq_section u_section (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_sample   (r_sample),
        .i_coefs    (coefs),
        .o_dac_code (n_code),
        .o_clipped  (n_clip)
    );

    // Control flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload: hold unless the stage moves.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_sample <= i_in.adc_sample;
        end
        if (advance) begin
            r_code <= n_code;
            r_clip <= n_clip;
        end
    end

    assign o_out.valid    = r_out_vld;
    assign o_out.dac_code = r_code;
    assign o_out.clipped  = r_clip;

endmodule

// ===== sv/biq_coef_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad coefficient registers
// Five Q2.14 coefficients, written by index; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module biq_coef_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  biq_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [biq_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output biq_pkg::t_coefs                o_coefs
);

    biq_pkg::t_coefs r_coefs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.b0 <= biq_pkg::B0_RESET;
            r_coefs.b1 <= biq_pkg::B1_RESET;
            r_coefs.b2 <= biq_pkg::B2_RESET;
            r_coefs.a1 <= biq_pkg::A1_RESET;
            r_coefs.a2 <= biq_pkg::A2_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                biq_pkg::CFG_B0: r_coefs.b0 <= $signed(i_cfg_data);
                biq_pkg::CFG_B1: r_coefs.b1 <= $signed(i_cfg_data);
                biq_pkg::CFG_B2: r_coefs.b2 <= $signed(i_cfg_data);
                biq_pkg::CFG_A1: r_coefs.a1 <= $signed(i_cfg_data);
                biq_pkg::CFG_A2: r_coefs.a2 <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign o_coefs = r_coefs;

endmodule

// ===== sv/biq_section.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad section
// Direct-form-I arithmetic with sample and output history, DAC clamp.
// ----------------------------------------------------------------------------
module biq_section (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_advance,
    input  logic [biq_pkg::SAMPLE_BITS-1:0] i_sample,
    input  biq_pkg::t_coefs                 i_coefs,
    output logic [biq_pkg::CODE_W-1:0]      o_dac_code,
    output logic                            o_clipped
);

    logic [biq_pkg::SAMPLE_BITS-1:0] r_in_1, r_in_2;
    logic signed [biq_pkg::Y_W-1:0]  r_out_1, r_out_2;

    logic signed [biq_pkg::SAMPLE_BITS:0]  s0, s1, s2;
    logic signed [biq_pkg::FF_P_W-1:0]     p0, p1, p2;
    logic signed [biq_pkg::FB_P_W-1:0]     q1, q2;
    logic signed [biq_pkg::FF_W-1:0]       ff;
    logic signed [biq_pkg::FB_W-1:0]       fb;
    logic signed [biq_pkg::ACC_W-1:0]      acc;
    logic signed [biq_pkg::YW_W-1:0]       y_wide;
    logic signed [biq_pkg::Y_W-1:0]        n_y;
    logic [biq_pkg::YW_W-biq_pkg::Y_W:0]   y_top;
    logic [biq_pkg::IP_W-1:0]              ip;

    always_comb begin
        s0 = $signed({1'b0, i_sample});
        s1 = $signed({1'b0, r_in_1});
        s2 = $signed({1'b0, r_in_2});
        p0 = i_coefs.b0 * s0;
        p1 = i_coefs.b1 * s1;
        p2 = i_coefs.b2 * s2;
        q1 = i_coefs.a1 * r_out_1;
        q2 = i_coefs.a2 * r_out_2;
        ff = biq_pkg::FF_W'(p0) + biq_pkg::FF_W'(p1) + biq_pkg::FF_W'(p2);
        fb = biq_pkg::FB_W'(q1) + biq_pkg::FB_W'(q2);
        acc = (biq_pkg::ACC_W'(ff) <<< biq_pkg::OUT_FRAC_BITS)
            + (biq_pkg::ACC_W'(fb) <<< biq_pkg::IN_FRAC_BITS);
        // Floor shift drops the coefficient and sample fraction bits.
        y_wide = $signed(acc[biq_pkg::ACC_W-1:biq_pkg::ACC_SHIFT]);
        // Saturate: all bits from the 32-bit sign up must agree.
        y_top = y_wide[biq_pkg::YW_W-1:biq_pkg::Y_W-1];
        if ((&y_top) || !(|y_top)) begin
            n_y = y_wide[biq_pkg::Y_W-1:0];
        end else if (y_wide[biq_pkg::YW_W-1]) begin
            n_y = {1'b1, {(biq_pkg::Y_W-1){1'b0}}};
        end else begin
            n_y = {1'b0, {(biq_pkg::Y_W-1){1'b1}}};
        end
        // Clamp the integer part to the DAC range.
        ip = n_y[biq_pkg::Y_W-1:biq_pkg::OUT_FRAC_BITS];
        if (n_y[biq_pkg::Y_W-1]) begin
            o_dac_code = '0;
            o_clipped  = 1'b1;
        end else if (|ip[biq_pkg::IP_W-1:biq_pkg::CODE_W]) begin
            o_dac_code = '1;
            o_clipped  = 1'b1;
        end else begin
            o_dac_code = ip[biq_pkg::CODE_W-1:0];
            o_clipped  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_1  <= '0;
            r_in_2  <= '0;
            r_out_1 <= '0;
            r_out_2 <= '0;
        end else if (i_advance) begin
            r_in_2  <= r_in_1;
            r_in_1  <= i_sample;
            r_out_2 <= r_out_1;
            r_out_1 <= n_y;
        end
    end

endmodule

// ===== tb/biquad_iir_sample_filter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad IIR sample filter testbench
// Streams ADC samples through the filter under many coefficient sets and
// compares every DAC word against a cycle-free fixed-point model of the
// direct-form-I biquad kept inside a small scoreboard class.
// ----------------------------------------------------------------------------
module biquad_iir_sample_filter_test;
    import biq_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 5;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 300;
    localparam int TAIL_CYCLES  = 16;
    localparam int PHASE_ITEMS  = 240;
    localparam int ZERO_ITEMS   = 60;
    localparam int SAT_RUN      = 10;

    localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;
    localparam int GAIN_MAX   = (1 << (COEF_W - 1)) - 1;
    localparam int GAIN_MIN   = -(1 << (COEF_W - 1));
    localparam int GAIN_ONE   = 1 << COEF_FRAC_BITS;

    typedef enum {
        GAINS_DEFAULT, GAINS_PASS, GAINS_ZERO, GAINS_MAXED,
        GAINS_MINNED, GAINS_STABLE, GAINS_WILD
    } t_gain_kind;

    typedef struct {
        logic [CODE_W-1:0] dac_code;
        logic              clipped;
    } t_dac_word;

    // ------------------------------------------------------------------------
    // DAC word tracker: holds its own copy of the gains and the filter
    // history, computes the word each accepted sample must produce and checks
    // the words coming out of the block in order.
    // ------------------------------------------------------------------------
    class dac_code_tracker;
        localparam int MAX_REPORTS = 10;

        t_coefs                  gains;
        logic [SAMPLE_BITS-1:0]  smp_1, smp_2;
        logic signed [Y_W-1:0]   out_1, out_2;
        t_dac_word               pending_codes[$];
        int checked, clip_count, sat_count, mismatches;

        function new();
            gains.b0   = B0_RESET;
            gains.b1   = B1_RESET;
            gains.b2   = B2_RESET;
            gains.a1   = A1_RESET;
            gains.a2   = A2_RESET;
            smp_1      = '0;
            smp_2      = '0;
            out_1      = '0;
            out_2      = '0;
            checked    = 0;
            clip_count = 0;
            sat_count  = 0;
            mismatches = 0;
        endfunction

        // Drop writes to indexes past the last gain.
        function void set_gain(t_cfg_idx idx, logic [COEF_W-1:0] val);
            case (idx)
                CFG_B0:  gains.b0 = val;
                CFG_B1:  gains.b1 = val;
                CFG_B2:  gains.b2 = val;
                CFG_A1:  gains.a1 = val;
                CFG_A2:  gains.a2 = val;
                default: ;
            endcase
        endfunction

        function void note_sample(logic [SAMPLE_BITS-1:0] smp);
            longint    ff, fb, acc, y, whole;
            t_dac_word w;
            // Exact products: Q2.14 gain times Q.2 sample or Q.8 output.
            ff = longint'(gains.b0) * longint'(smp)
               + longint'(gains.b1) * longint'(smp_1)
               + longint'(gains.b2) * longint'(smp_2);
            fb = longint'(gains.a1) * longint'(out_1)
               + longint'(gains.a2) * longint'(out_2);
            // Align both sums to 16 + OUT_FRAC_BITS fraction bits, then floor.
            acc = ff * (longint'(1) << OUT_FRAC_BITS) + fb * (longint'(1) << IN_FRAC_BITS);
            y   = acc >>> ACC_SHIFT;
            if (y > (longint'(1) << (Y_W - 1)) - 1) begin
                y = (longint'(1) << (Y_W - 1)) - 1;
                sat_count++;
            end else if (y < -(longint'(1) << (Y_W - 1))) begin
                y = -(longint'(1) << (Y_W - 1));
                sat_count++;
            end
            // Advance the history with the saturated output.
            out_2 = out_1;
            out_1 = Y_W'(y);
            smp_2 = smp_1;
            smp_1 = smp;
            // Clamp the integer part into the DAC range.
            if (y < 0) begin
                w.dac_code = '0;
                w.clipped  = 1'b1;
            end else begin
                whole = y >>> OUT_FRAC_BITS;
                if (whole > (1 << CODE_W) - 1) begin
                    w.dac_code = '1;
                    w.clipped  = 1'b1;
                end else begin
                    w.dac_code = CODE_W'(whole);
                    w.clipped  = 1'b0;
                end
            end
            if (w.clipped) clip_count++;
            pending_codes.push_back(w);
        endfunction

        function void check_code(logic [CODE_W-1:0] code, logic clip, int cyc);
            t_dac_word want;
            if (pending_codes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("cycle %0d: unexpected word dac_code=%0d clipped=%0b",
                             cyc, code, clip);
                return;
            end
            want = pending_codes.pop_front();
            checked++;
            if (code !== want.dac_code || clip !== want.clipped) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("cycle %0d word %0d: code exp %0d got %0d, clip exp %0b got %0b",
                             cyc, checked, want.dac_code, code, want.clipped, clip);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, channels and the block
    // ------------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    t_cfg_idx              i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    biq_in_if  in_ch ();
    biq_out_if out_ch ();

    biquad_iir_sample_filter uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    dac_code_tracker tracker;
    int  cycle_count   = 0;
    int  stall_left    = 0;
    int  samples_sent  = 0;
    int  settings_used = 0;
    bit  idle_on       = 1'b0;
    bit  long_hold_req = 1'b0;

    t_gain_kind phase_plan[$] = '{GAINS_PASS, GAINS_STABLE, GAINS_MAXED, GAINS_STABLE,
                                  GAINS_WILD, GAINS_MINNED, GAINS_ZERO, GAINS_STABLE,
                                  GAINS_DEFAULT};

    localparam logic [SAMPLE_BITS-1:0] OPENING [6] = '{0, 4095, 4095, 0, 2730, 1365};

    // Kill the run if the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout at cycle %0d with %0d words outstanding",
                     cycle_count, tracker.pending_codes.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Output side: check each accepted word, then pick ready for the next
    // edge. A long hold-off requested by the sender runs here, counted in
    // cycles, so the sender keeps offering samples while the block backs up.
    always @(posedge i_clk) begin
        if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            tracker.check_code(out_ch.dac_code, out_ch.clipped, cycle_count);
        if (long_hold_req) begin
            stall_left    = LONG_HOLD;
            long_hold_req = 1'b0;
        end else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 10);
        end
        if (!i_rst_n || stall_left > 0) begin
            out_ch.ready <= 1'b0;
            if (stall_left > 0) stall_left--;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Offer one sample, optionally after an idle burst, and hold it until
    // the block takes it. Valid stays high on return so back-to-back words
    // do not drop it.
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 10);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.adc_sample <= smp;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        tracker.note_sample(smp);
        samples_sent++;
    endtask

    task automatic wait_drained();
        while (tracker.pending_codes.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        tracker.set_gain(idx, val);
    endtask

    // Load all five gains, then poke an unused index that must be dropped.
    task automatic program_gains(input t_coefs g);
        write_reg(CFG_B0, g.b0);
        write_reg(CFG_B1, g.b1);
        write_reg(CFG_B2, g.b2);
        write_reg(CFG_A1, g.a1);
        write_reg(CFG_A2, g.a2);
        write_reg(t_cfg_idx'($urandom_range(NUM_COEFS, (1 << CFG_IDX_W) - 1)),
                  CFG_DATA_W'($urandom()));
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic t_coefs pick_gains(t_gain_kind kind);
        t_coefs g;
        int     a2, a1_lim;
        g = '0;
        case (kind)
            GAINS_DEFAULT: begin
                g.b0 = B0_RESET;
                g.b1 = B1_RESET;
                g.b2 = B2_RESET;
                g.a1 = A1_RESET;
                g.a2 = A2_RESET;
            end
            GAINS_PASS:   g.b0 = COEF_W'(GAIN_ONE);
            GAINS_ZERO:   ;
            GAINS_MAXED:  g = {NUM_COEFS{COEF_W'(GAIN_MAX)}};
            GAINS_MINNED: g = {NUM_COEFS{COEF_W'(GAIN_MIN)}};
            GAINS_STABLE: begin
                // Keep poles inside the unit circle: |a2| < 1, |a1| < 1 - a2.
                a2     = -int'($urandom_range(0, 14000));
                a1_lim = ((GAIN_ONE - a2) * 9) / 10;
                g.a2   = COEF_W'(a2);
                g.a1   = COEF_W'(int'($urandom_range(0, 2 * a1_lim)) - a1_lim);
                g.b0   = COEF_W'(int'($urandom_range(0, 2 * GAIN_ONE)) - GAIN_ONE);
                g.b1   = COEF_W'(int'($urandom_range(0, 2 * GAIN_ONE)) - GAIN_ONE);
                g.b2   = COEF_W'(int'($urandom_range(0, 2 * GAIN_ONE)) - GAIN_ONE);
            end
            GAINS_WILD:   g = t_coefs'({$urandom(), $urandom(), COEF_W'($urandom())});
            default:      ;
        endcase
        return g;
    endfunction

    // Mix rail values, slow drifts and uniform noise.
    function automatic logic [SAMPLE_BITS-1:0] next_sample(logic [SAMPLE_BITS-1:0] last);
        int pick, v;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            v = 0;
        end else if (pick == 1) begin
            v = SAMPLE_MAX;
        end else if (pick < 5) begin
            v = int'(last) + int'($urandom_range(0, 256)) - 128;
            if (v < 0) v = 0;
            if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        end else begin
            v = $urandom_range(0, SAMPLE_MAX);
        end
        return SAMPLE_BITS'(v);
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_coefs                 g;
        logic [SAMPLE_BITS-1:0] smp;
        int                     n;

        tracker          = new();
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = CFG_B0;
        i_cfg_data       = '0;
        in_ch.valid      = 1'b0;
        in_ch.adc_sample = '0;
        out_ch.ready     = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset gains, both rails and alternating bit patterns.
        idle_on = 1'b1;
        foreach (OPENING[k]) send_sample(OPENING[k]);
        in_ch.valid <= 1'b0;
        wait_drained();

        // Directed: runaway growth into positive saturation.
        program_gains(pick_gains(GAINS_MAXED));
        repeat (SAT_RUN) send_sample(SAMPLE_MAX);
        in_ch.valid <= 1'b0;
        wait_drained();

        // Directed: runaway growth into negative saturation.
        g    = '0;
        g.b0 = COEF_W'(GAIN_MIN);
        g.b1 = COEF_W'(GAIN_MIN);
        g.b2 = COEF_W'(GAIN_MIN);
        g.a1 = COEF_W'(GAIN_MAX);
        g.a2 = COEF_W'(GAIN_MAX);
        program_gains(g);
        repeat (SAT_RUN) send_sample(SAMPLE_MAX);
        in_ch.valid <= 1'b0;
        wait_drained();

        // Random phases, one coefficient set each; the last one runs flat out.
        foreach (phase_plan[p]) begin
            program_gains(pick_gains(phase_plan[p]));
            n   = (phase_plan[p] == GAINS_ZERO) ? ZERO_ITEMS : PHASE_ITEMS;
            smp = '0;
            for (int k = 0; k < n; k++) begin
                idle_on = (p != phase_plan.size() - 1) && ((k / 80) % 3 != 2);
                // Pause the sender until every word is back.
                if (p == 1 && k == n / 2) begin
                    in_ch.valid <= 1'b0;
                    wait_drained();
                end
                // Back up the block with a long output hold-off.
                if (p == 3 && k == n / 3) long_hold_req = 1'b1;
                smp = next_sample(smp);
                send_sample(smp);
            end
            in_ch.valid <= 1'b0;
            wait_drained();
        end

        // Let any stray word show up before judging.
        idle_on = 1'b0;
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d samples over %0d coefficient sets, %0d words checked.",
                 samples_sent, settings_used, tracker.checked);
        $display("Saw %0d clipped codes, %0d saturated outputs, %0d mismatches.",
                 tracker.clip_count, tracker.sat_count, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending_codes.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== biquad_iir_sample_filter.f =====
sv/biq_pkg.sv
sv/biq_if.sv
sv/biq_coef_regs.sv
sv/biq_section.sv
sv/biquad_iir_sample_filter.sv
tb/biquad_iir_sample_filter_test.sv
